>>> src/ptag_pkg.sv
// ----------------------------------------------------------------------------
// ptag_pkg
// Payload types, register indexes and arctangent table for pan/tilt aiming.
// ----------------------------------------------------------------------------
package ptag_pkg;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] robot_pos_x;
        logic signed [15:0] robot_pos_y;
        logic signed [15:0] robot_heading;
        logic signed [15:0] model_bearing;
        logic signed [15:0] model_slope;
    } aim_in_t;

    typedef struct packed {
        logic signed [15:0] pan_angle;
        logic signed [15:0] tilt_angle;
    } aim_out_t;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

    localparam int ATAN_LEN = 24;

    // atan(2^-i) with a full turn as 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> src/pan_tilt_aim_geometry.sv
// ----------------------------------------------------------------------------
// pan_tilt_aim_geometry
// Camera pan and tilt from a pose, pipelined CORDIC atan2 and integer sqrt.
// ----------------------------------------------------------------------------
//  channel   signals                       direction  meaning
//  command   start, busy, cmd              in / out   one pose per beat
//  result    done, res                     out        one angle pair per beat
//  config    cfg_we, cfg_idx, cfg_data     in         register write
//
//  One beat enters per cycle; busy is tied low. Each command passes
//  through differences and squares, a square root of 18 stages with
//  one root bit each, the quadrant fold, then the CORDIC chain, then
//  a final rounding stage, and leaves as a result. rst_n clears the
//  configuration registers and every valid bit. The receiver cannot
//  stall, so nothing ever holds.
// ----------------------------------------------------------------------------
module pan_tilt_aim_geometry #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ptag_pkg::aim_in_t               cmd,
    output logic                            done,
    output ptag_pkg::aim_out_t              res,
    input  logic                            cfg_we,
    input  logic [ptag_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ptag_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptag_pkg::*;

    localparam int NST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int SQ  = 18;         // 1 root bit per stage, 18-bit root
    localparam int CW  = 44;         // 17 bits + 24 prescale + growth
    localparam int DEPTH = 1 + SQ + 1 + NST + 1;

    // ---------------- configuration ----------------
    logic        mode_reg;
    logic [15:0] heading_reg;
    logic [11:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            heading_reg <= '0;
            height_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_MODE:    mode_reg    <= cfg_data[0];
                REG_HEADING: heading_reg <= cfg_data[15:0];
                REG_HEIGHT:  height_reg  <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- valid chain ----------------
    logic [DEPTH-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DEPTH-2:0], start};
    end

    // Side data carried along: precomputed model result, mode, pan offset, height
    typedef struct packed {
        logic        mode;
        logic [15:0] mpan;
        logic [15:0] mtilt;
        logic [15:0] off;    // robot_heading + camera_heading
        logic [11:0] h;
    } side_t;

    // ---------------- stage 0: differences and squares ----------------
    logic signed [16:0] dx_reg, dy_reg;
    logic [34:0]        sq_reg;
    side_t              s0_reg;
    logic signed [16:0] dx_c, dy_c;
    always_comb
    begin
        dx_c = 17'(cmd.target_x) - 17'(cmd.robot_pos_x);
        dy_c = 17'(cmd.target_y) - 17'(cmd.robot_pos_y);
    end
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_c;
        dy_reg <= dy_c;
        sq_reg <= 35'(unsigned'(34'(dx_c * dx_c))) + 35'(unsigned'(34'(dy_c * dy_c)));
        s0_reg.mode  <= mode_reg;
        s0_reg.mpan  <= 16'(cmd.model_bearing) - heading_reg;
        s0_reg.mtilt <= cmd.model_slope;
        s0_reg.off   <= 16'(cmd.robot_heading) + heading_reg;
        s0_reg.h     <= height_reg;
    end

    // ---------------- square root, 2 radicand bits per stage ----------------
    logic [35:0]        rem_reg [SQ+1];
    logic [17:0]        root_reg[SQ+1];
    logic [35:0]        nrm_reg [SQ+1];
    logic signed [16:0] sdx_reg [SQ+1];
    logic signed [16:0] sdy_reg [SQ+1];
    side_t              ss_reg  [SQ+1];
    always_comb
    begin
        rem_reg[0]  = 36'(sq_reg);
        root_reg[0] = '0;
        nrm_reg[0]  = '0;
        sdx_reg[0]  = dx_reg;
        sdy_reg[0]  = dy_reg;
        ss_reg[0]   = s0_reg;
    end
    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        logic [35:0] n_c, t_c;
        logic [19:0] trial;
        always_comb
        begin
            n_c   = {nrm_reg[k][33:0], rem_reg[k][35:34]};
            trial = {root_reg[k], 2'b01};
            t_c   = n_c - 36'(trial);
        end
        always_ff @(posedge clk)
        begin
            if (n_c >= 36'(trial))
            begin
                nrm_reg[k+1]  <= t_c;
                root_reg[k+1] <= {root_reg[k][16:0], 1'b1};
            end
            else
            begin
                nrm_reg[k+1]  <= n_c;
                root_reg[k+1] <= {root_reg[k][16:0], 1'b0};
            end
            rem_reg[k+1] <= {rem_reg[k][33:0], 2'b00};
            sdx_reg[k+1] <= sdx_reg[k];
            sdy_reg[k+1] <= sdy_reg[k];
            ss_reg[k+1]  <= ss_reg[k];
        end
    end

    // ---------------- CORDIC setup (quadrant fold) ----------------
    logic signed [CW-1:0] ax_reg[NST+1], ay_reg[NST+1];
    logic signed [CW-1:0] bx_reg[NST+1], by_reg[NST+1];
    logic [31:0]          aa_reg[NST+1], ba_reg[NST+1];
    logic                 az_reg[NST+1], bz_reg[NST+1];
    side_t                cs_reg[NST+1];

    logic signed [CW-1:0] px_c, py_c, tx_c, ty_c;
    always_comb
    begin
        px_c = CW'(sdx_reg[SQ]) <<< 24;
        py_c = CW'(sdy_reg[SQ]) <<< 24;
        tx_c = CW'(signed'({1'b0, root_reg[SQ]})) <<< 24;
        ty_c = CW'(signed'({1'b0, ss_reg[SQ].h})) <<< 24;
    end
    always_ff @(posedge clk)
    begin
        if (px_c < 0)
        begin
            ax_reg[0] <= -px_c;
            ay_reg[0] <= -py_c;
            aa_reg[0] <= 32'h80000000;
        end
        else
        begin
            ax_reg[0] <= px_c;
            ay_reg[0] <= py_c;
            aa_reg[0] <= '0;
        end
        az_reg[0] <= (px_c == 0) && (py_c == 0);
        bx_reg[0] <= tx_c;       // distance never negative
        by_reg[0] <= ty_c;
        ba_reg[0] <= '0;
        bz_reg[0] <= (tx_c == 0) && (ty_c == 0);
        cs_reg[0] <= ss_reg[SQ];
    end

    // Two vectoring chains side by side: bearing and tilt
    for (genvar i = 0; i < NST; i++)
    begin : g_cordic
        localparam logic [31:0] ANG = atan_turn(5'(i));
        always_ff @(posedge clk)
        begin
            if (ay_reg[i] >= 0)
            begin
                ax_reg[i+1] <= ax_reg[i] + (ay_reg[i] >>> i);
                ay_reg[i+1] <= ay_reg[i] - (ax_reg[i] >>> i);
                aa_reg[i+1] <= aa_reg[i] + ANG;
            end
            else
            begin
                ax_reg[i+1] <= ax_reg[i] - (ay_reg[i] >>> i);
                ay_reg[i+1] <= ay_reg[i] + (ax_reg[i] >>> i);
                aa_reg[i+1] <= aa_reg[i] - ANG;
            end
            if (by_reg[i] >= 0)
            begin
                bx_reg[i+1] <= bx_reg[i] + (by_reg[i] >>> i);
                by_reg[i+1] <= by_reg[i] - (bx_reg[i] >>> i);
                ba_reg[i+1] <= ba_reg[i] + ANG;
            end
            else
            begin
                bx_reg[i+1] <= bx_reg[i] - (by_reg[i] >>> i);
                by_reg[i+1] <= by_reg[i] + (bx_reg[i] >>> i);
                ba_reg[i+1] <= ba_reg[i] - ANG;
            end
            az_reg[i+1] <= az_reg[i];
            bz_reg[i+1] <= bz_reg[i];
            cs_reg[i+1] <= cs_reg[i];
        end
    end

    // ---------------- round, offset, select ----------------
    logic [31:0] ar_c, br_c;
    logic [15:0] bear_c, tilt_c;
    aim_out_t    res_reg;
    always_comb
    begin
        ar_c   = aa_reg[NST] + 32'h8000;
        br_c   = ba_reg[NST] + 32'h8000;
        bear_c = az_reg[NST] ? 16'h0 : ar_c[31:16];
        tilt_c = bz_reg[NST] ? 16'h0 : br_c[31:16];
    end
    always_ff @(posedge clk)
    begin
        if (cs_reg[NST].mode)
        begin
            res_reg.pan_angle  <= bear_c - cs_reg[NST].off;
            res_reg.tilt_angle <= tilt_c;
        end
        else
        begin
            res_reg.pan_angle  <= cs_reg[NST].mpan;
            res_reg.tilt_angle <= cs_reg[NST].mtilt;
        end
    end

    assign done = vld_reg[DEPTH-1];
    assign res  = res_reg;

    // ---------------- assertions ----------------
    a_busy_low: assert property (@(posedge clk) busy == 1'b0)
        else $error("busy asserted");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> ##(DEPTH-1) done)
        else $error("result beat missing");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> vld_reg[DEPTH-2] == 1'b0 || $past(vld_reg[DEPTH-2]))
        else $error("result without command");
endmodule
